/* sv/frbs_pkg.sv */
// ----------------------------------------------------------------------------
// frbs_pkg
// Shared types and constants for the frame-relative byte stack.
// ----------------------------------------------------------------------------
package frbs_pkg;

	// Field widths of the stream items.
	localparam int CMD_W  = 3;
	localparam int VAL_W  = 8;
	localparam int OFF_W  = 11;
	localparam int STAT_W = 2;

	// Default stack capacity in bytes.
	localparam int DEFAULT_STACK_DEPTH = 1024;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SETFB = 3'd4;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic exec;
		logic load_out;
	} frbs_ctl_t;

endpackage

/* sv/frbs_ctrl.sv */
// ----------------------------------------------------------------------------
// frbs_ctrl
// Controller: sequences capture, evaluation and result load for each command
// and owns the handshake flags of both stream sides.
// ----------------------------------------------------------------------------
module frbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output frbs_pkg::frbs_ctl_t ctl
);
	import frbs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WB
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	// The output register is free when empty or being emptied this cycle.
	assign out_free = !m_tvalid_q || m_tready;

	// A new command may be captured while the previous result is loaded.
	always_comb begin
		s_tready     = (state_q == S_IDLE) || ((state_q == S_WB) && out_free);
		ctl.load_in  = s_tvalid && s_tready;
		ctl.exec     = (state_q == S_EXEC);
		ctl.load_out = (state_q == S_WB) && out_free;
	end

	assign m_tvalid = m_tvalid_q;

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				S_EXEC: begin
					state_q <= S_WB;
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				S_WB: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= s_tvalid ? S_EXEC : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A captured command is always evaluated in the next cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_in |=> (state_q == S_EXEC))
		else $error("accepted command not evaluated");

	// The result register fills only from the write-back state.
	a_rise_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_WB))
		else $error("result valid raised outside write-back");

	// No capture during evaluation.
	a_no_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !s_tready)
		else $error("input ready during evaluation");

endmodule

/* sv/frbs_datapath.sv */
// ----------------------------------------------------------------------------
// frbs_datapath
// Datapath: command register, count and frame base registers, byte store,
// range checks and the result register.
// ----------------------------------------------------------------------------
module frbs_datapath #(
	parameter int STACK_DEPTH = frbs_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  frbs_pkg::frbs_ctl_t         ctl,
	input  logic [frbs_pkg::CMD_W-1:0]  command,
	input  logic [frbs_pkg::VAL_W-1:0]  value,
	input  logic [frbs_pkg::OFF_W-1:0]  offset,
	output logic [frbs_pkg::VAL_W-1:0]  read_data,
	output logic [frbs_pkg::STAT_W-1:0] status
);
	import frbs_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = ((CW > OFF_W) ? CW : OFF_W) + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(STACK_DEPTH);

	// Captured command.
	logic [CMD_W-1:0] cmd_q;
	logic [VAL_W-1:0] val_q;
	logic [OFF_W-1:0] off_q;

	// Stack state.
	logic [CW-1:0] count_q;
	logic [CW-1:0] base_q;

	// Byte store.
	logic [VAL_W-1:0] mem [STACK_DEPTH];
	logic [VAL_W-1:0] rd_q;

	// Evaluation results.
	logic [STAT_W-1:0] status_q;
	logic              take_q;
	logic [VAL_W-1:0]  out_data_q;
	logic [STAT_W-1:0] out_status_q;

	logic [SW-1:0]     sum_push;
	logic [SW-1:0]     sum_off;
	logic [SW-1:0]     idx;
	logic [AW-1:0]     addr;
	logic              we;
	logic              take_d;
	logic [STAT_W-1:0] status_d;
	logic [CW-1:0]     count_d;
	logic [CW-1:0]     base_d;

	// Capture the accepted command.
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= command;
			val_q <= value;
			off_q <= offset;
		end
	end

	// Address arithmetic and range checks.
	always_comb begin
		sum_push = SW'(base_q) + SW'(count_q);
		sum_off  = SW'(base_q) + SW'(off_q);
		idx      = sum_off;
		we       = 1'b0;
		take_d   = 1'b0;
		status_d = STAT_OK;
		count_d  = count_q;
		base_d   = base_q;
		case (cmd_q)
			CMD_PUSH: begin
				idx = sum_push;
				if (sum_push >= DEPTH_S) begin
					status_d = STAT_OVERFLOW;
				end else begin
					we      = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			CMD_POP: begin
				idx = sum_push - SW'(1);
				if (count_q == '0) begin
					status_d = STAT_UNDERFLOW;
				end else if (sum_push > DEPTH_S) begin
					status_d = STAT_RANGE;
				end else begin
					take_d  = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			CMD_WRITE: begin
				if (sum_off >= DEPTH_S) begin
					status_d = STAT_RANGE;
				end else begin
					we = 1'b1;
				end
			end
			CMD_READ: begin
				if (sum_off >= DEPTH_S) begin
					status_d = STAT_RANGE;
				end else begin
					take_d = 1'b1;
				end
			end
			CMD_SETFB: begin
				if (SW'(off_q) > DEPTH_S) begin
					status_d = STAT_RANGE;
				end else begin
					base_d = CW'(off_q);
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
		addr = idx[AW-1:0];
	end

	// Single-port store with registered read data.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (we) begin
				mem[addr] <= val_q;
			end
			rd_q <= mem[addr];
		end
	end

	// Count and frame base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			base_q  <= '0;
		end else if (ctl.exec) begin
			count_q <= count_d;
			base_q  <= base_d;
		end
	end

	// Evaluation flags, then the result register.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q <= status_d;
			take_q   <= take_d;
		end
		if (ctl.load_out) begin
			out_data_q   <= take_q ? rd_q : '0;
			out_status_q <= status_q;
		end
	end

	assign read_data = out_data_q;
	assign status    = out_status_q;

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("count above capacity");

	// The frame base never passes the capacity.
	a_base_bound: assert property (@(posedge clk) disable iff (!arst_n)
		base_q <= CW'(STACK_DEPTH))
		else $error("frame base above capacity");

	// A successful push raises the count by one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && (cmd_q == CMD_PUSH) && (status_d == STAT_OK))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not raise count");

endmodule

/* sv/frame_relative_byte_stack_top.sv */
// Each accepted command is captured, then evaluated with the registered store read, then loaded
// into the result register, the load waiting while the previous result is not taken; the next
// command is captured during that load, but no command is captured during evaluation.
// Reset: count and frame base clear to zero, both handshakes idle; the byte store is not cleared.
// ----------------------------------------------------------------------------
// frame_relative_byte_stack_top
// Byte stack with a frame base register for a virtual machine, with push,
// pop, frame-relative write and read, and frame base load, each giving a
// data byte and a status code.
// ----------------------------------------------------------------------------
module frame_relative_byte_stack_top #(
	parameter int STACK_DEPTH = frbs_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // command[2:0], value[10:3], offset[21:11], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_data[7:0], status[9:8], zeros
);
	import frbs_pkg::*;

	frbs_ctl_t         ctl;
	logic [VAL_W-1:0]  read_data;
	logic [STAT_W-1:0] status;

	// Handshake and sequencing.
	frbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl)
	);

	// Store, registers and checks.
	frbs_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.command   (s_tdata[2:0]),
		.value     (s_tdata[10:3]),
		.offset    (s_tdata[21:11]),
		.read_data (read_data),
		.status    (status)
	);

	assign m_tdata = {6'd0, status, read_data};

endmodule
